FILE: rtl/differential_odometry_accumulator_core_assert.svh
// assertion macros shared by the odometry accumulator rtl
// no dependencies; included by the modules that carry checks
`ifndef DIFFERENTIAL_ODOMETRY_ACCUMULATOR_CORE_ASSERT_SVH
`define DIFFERENTIAL_ODOMETRY_ACCUMULATOR_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define DOA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define DOA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/doa_pkg.sv
// shared types, widths and constants for the odometry accumulator
// no dependencies; used by every module of the block
`default_nettype none

package doa_pkg;

    // input delta width
    localparam int DELTA_WIDTH = 16;
    localparam int SUM_W       = DELTA_WIDTH + 1;

    // configuration register widths and reset values
    localparam int WD_W       = 10;
    localparam int TW_W       = 11;
    localparam int CPR_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [WD_W-1:0]  WD_RESET  = WD_W'(65);
    localparam logic [TW_W-1:0]  TW_RESET  = TW_W'(160);
    localparam logic [CPR_W-1:0] CPR_RESET = CPR_W'(1560);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_DIAMETER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_REV = 2'd2;

    // arithmetic widths
    localparam int ACC_W  = 32;
    localparam int NUM_W  = 64;
    localparam int KD_W   = 42;
    localparam int KH_W   = 28;
    localparam int DDEN_W = 37;
    localparam int HDEN_W = 27;
    localparam int DREM_W = 38;
    localparam int HREM_W = 28;

    // scale factors: pi*1e6 times um per mm, mdeg per half turn, 2 * 1e6
    localparam logic [31:0] DIST_K = 32'd3141593000;
    localparam logic [17:0] MDEG_K = 18'd180000;
    localparam logic [20:0] DEN_K  = 21'd2000000;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // command classes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_SKIP   = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;

    typedef struct packed {
        logic signed [DELTA_WIDTH-1:0] left_delta;
        logic signed [DELTA_WIDTH-1:0] right_delta;
        logic                          clear_totals;
    } t_in;

    typedef struct packed {
        logic signed [ACC_W-1:0] distance_total;
        logic signed [ACC_W-1:0] heading_total;
        logic                    valid_res;
    } t_out;

    typedef struct packed {
        logic [WD_W-1:0]  wheel_diameter;
        logic [TW_W-1:0]  track_width;
        logic [CPR_W-1:0] counts_per_rev;
    } t_cfg;

    typedef struct packed {
        logic [1:0]              op;
        logic                    ok;
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] diff;
    } t_cmd;

endpackage

`default_nettype wire

FILE: rtl/doa_div.sv
// unsigned restoring divider, one quotient bit per cycle
// depends on doa_pkg for default widths
`default_nettype none

module doa_div #(
    parameter int NUM_W = doa_pkg::NUM_W,
    parameter int DEN_W = doa_pkg::DDEN_W
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic      [NUM_W-1:0] o_quo,
    output logic      [DEN_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   w_trial;
    logic             w_fit;
    logic [DEN_W-1:0] n_rem;

    // trial subtract of the shifted partial remainder
    always_comb begin
        w_trial = {r_rem, r_quo[NUM_W-1]};
        w_fit   = (w_trial >= {1'b0, r_den});
        n_rem   = w_fit ? DEN_W'(w_trial - {1'b0, r_den}) : DEN_W'(w_trial);
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // numerator bits shift out while quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], w_fit};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

FILE: rtl/doa_front.sv
// front end: accepts items, classifies them and queues commands
// depends on doa_pkg
`default_nettype none

module doa_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire doa_pkg::t_cfg i_cfg,
    input  wire logic          i_push,
    input  wire doa_pkg::t_in  i_item,
    output logic               o_full,
    output logic               o_cmd_valid,
    output doa_pkg::t_cmd      o_cmd,
    input  wire logic          i_cmd_take
);

    `include "differential_odometry_accumulator_core_assert.svh"

    doa_pkg::t_cmd r_q [doa_pkg::QUEUE_DEPTH];
    logic [doa_pkg::QPTR_W-1:0] r_wp;
    logic [doa_pkg::QPTR_W-1:0] r_rp;
    logic [doa_pkg::QCNT_W-1:0] r_cnt;

    logic          w_ok;
    logic          w_push_ok;
    logic          w_take_ok;
    doa_pkg::t_cmd w_cmd;

    // classify the item and form the wheel sum and difference
    always_comb begin
        w_ok = (i_cfg.wheel_diameter != '0) && (i_cfg.track_width != '0) &&
               (i_cfg.counts_per_rev != '0);
        w_cmd.ok   = w_ok;
        w_cmd.sum  = doa_pkg::SUM_W'(i_item.left_delta) +
                     doa_pkg::SUM_W'(i_item.right_delta);
        w_cmd.diff = doa_pkg::SUM_W'(i_item.right_delta) -
                     doa_pkg::SUM_W'(i_item.left_delta);
        if (i_item.clear_totals) begin
            w_cmd.op = doa_pkg::OP_CLEAR;
        end else if (!w_ok) begin
            w_cmd.op = doa_pkg::OP_SKIP;
        end else begin
            w_cmd.op = doa_pkg::OP_UPDATE;
        end
    end

    assign o_full      = (r_cnt == doa_pkg::QCNT_W'(doa_pkg::QUEUE_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign w_push_ok   = i_push && !o_full;
    assign w_take_ok   = i_cmd_take && o_cmd_valid;

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push_ok) begin
                r_wp <= r_wp + doa_pkg::QPTR_W'(1);
            end
            if (w_take_ok) begin
                r_rp <= r_rp + doa_pkg::QPTR_W'(1);
            end
            if (w_push_ok && !w_take_ok) begin
                r_cnt <= r_cnt + doa_pkg::QCNT_W'(1);
            end else if (w_take_ok && !w_push_ok) begin
                r_cnt <= r_cnt - doa_pkg::QCNT_W'(1);
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    `DOA_ASSERT_NEXT(a_cnt_inc, i_clk, i_rst_n, w_push_ok && !w_take_ok,
        r_cnt == $past(r_cnt) + doa_pkg::QCNT_W'(1), "queue level did not rise on push")
    `DOA_ASSERT_NEXT(a_cnt_dec, i_clk, i_rst_n, w_take_ok && !w_push_ok,
        r_cnt == $past(r_cnt) - doa_pkg::QCNT_W'(1), "queue level did not fall on take")
    `DOA_ASSERT_NOW(a_cnt_range, i_clk, i_rst_n, 1'b1,
        r_cnt <= doa_pkg::QCNT_W'(doa_pkg::QUEUE_DEPTH), "queue level beyond depth")

endmodule

`default_nettype wire

FILE: rtl/doa_back.sv
// back end: multiplies, divides and accumulates, holds the result register
// depends on doa_pkg and doa_div
`default_nettype none

module doa_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire doa_pkg::t_cfg i_cfg,
    input  wire logic          i_cmd_valid,
    input  wire doa_pkg::t_cmd i_cmd,
    output logic               o_cmd_take,
    output logic               o_empty,
    input  wire logic          i_pop,
    output doa_pkg::t_out      o_result
);

    `include "differential_odometry_accumulator_core_assert.svh"

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL1  = 3'd1;
    localparam logic [2:0] S_MUL2  = 3'd2;
    localparam logic [2:0] S_MUL3  = 3'd3;
    localparam logic [2:0] S_START = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // state of the odometer
    logic        [doa_pkg::ACC_W-1:0]  r_dacc;
    logic        [doa_pkg::ACC_W-1:0]  r_hacc;
    logic signed [doa_pkg::DREM_W-1:0] r_drem;
    logic signed [doa_pkg::HREM_W-1:0] r_hrem;
    logic                              r_ok;

    // datapath registers
    logic signed [doa_pkg::SUM_W-1:0]  r_sum;
    logic signed [doa_pkg::SUM_W-1:0]  r_diff;
    logic        [doa_pkg::KD_W-1:0]   r_kd;
    logic        [doa_pkg::KH_W-1:0]   r_kh;
    logic        [doa_pkg::DDEN_W-1:0] r_dden;
    logic        [doa_pkg::HDEN_W-1:0] r_hden;
    logic        [doa_pkg::NUM_W-1:0]  r_pdl;
    logic        [doa_pkg::ACC_W-1:0]  r_pdh;
    logic        [doa_pkg::NUM_W-1:0]  r_hn;
    logic        [doa_pkg::NUM_W-1:0]  r_dnum;
    logic        [doa_pkg::NUM_W-1:0]  r_hnum;

    // result register
    doa_pkg::t_out r_out;
    logic          r_out_valid;

    logic                        w_slot_free;
    logic                        w_div_start;
    logic [doa_pkg::NUM_W-1:0]   w_dabs;
    logic [doa_pkg::NUM_W-1:0]   w_habs;
    logic                        w_ddone;
    logic                        w_hdone;
    logic [doa_pkg::NUM_W-1:0]   w_dquo;
    logic [doa_pkg::NUM_W-1:0]   w_hquo;
    logic [doa_pkg::DDEN_W-1:0]  w_durem;
    logic [doa_pkg::HDEN_W-1:0]  w_hurem;
    logic [doa_pkg::NUM_W-1:0]   w_dq;
    logic [doa_pkg::NUM_W-1:0]   w_hq;
    logic [doa_pkg::DREM_W-1:0]  w_drem;
    logic [doa_pkg::HREM_W-1:0]  w_hrem;

    assign w_slot_free = !r_out_valid || i_pop;
    assign o_cmd_take  = (r_state == S_IDLE) && i_cmd_valid;
    assign w_div_start = (r_state == S_START);
    assign o_empty     = !r_out_valid;
    assign o_result    = r_out;

    // magnitudes fed to the dividers, denominators are always positive
    assign w_dabs = r_dnum[doa_pkg::NUM_W-1] ? -r_dnum : r_dnum;
    assign w_habs = r_hnum[doa_pkg::NUM_W-1] ? -r_hnum : r_hnum;

    doa_div #(
        .NUM_W (doa_pkg::NUM_W),
        .DEN_W (doa_pkg::DDEN_W)
    ) u_div_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_dabs),
        .i_den   (r_dden),
        .o_done  (w_ddone),
        .o_quo   (w_dquo),
        .o_rem   (w_durem)
    );

    doa_div #(
        .NUM_W (doa_pkg::NUM_W),
        .DEN_W (doa_pkg::HDEN_W)
    ) u_div_head (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_habs),
        .i_den   (r_hden),
        .o_done  (w_hdone),
        .o_quo   (w_hquo),
        .o_rem   (w_hurem)
    );

    // signs follow the numerators, division truncates toward zero
    always_comb begin
        w_dq   = r_dnum[doa_pkg::NUM_W-1] ? -w_dquo : w_dquo;
        w_hq   = r_hnum[doa_pkg::NUM_W-1] ? -w_hquo : w_hquo;
        w_drem = r_dnum[doa_pkg::NUM_W-1] ? -{1'b0, w_durem} : {1'b0, w_durem};
        w_hrem = r_hnum[doa_pkg::NUM_W-1] ? -{1'b0, w_hurem} : {1'b0, w_hurem};
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = (i_cmd.op == doa_pkg::OP_UPDATE) ? S_MUL1 : S_OUT;
                end
            end
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_MUL3;
            S_MUL3:  n_state = S_START;
            S_START: n_state = S_DIV;
            S_DIV: begin
                if (w_ddone) begin
                    n_state = S_FIN;
                end
            end
            S_FIN:   n_state = S_OUT;
            S_OUT: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control, totals and remainders
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dacc      <= '0;
            r_hacc      <= '0;
            r_drem      <= '0;
            r_hrem      <= '0;
            r_ok        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd_take) begin
                r_ok <= i_cmd.ok;
                if (i_cmd.op == doa_pkg::OP_CLEAR) begin
                    r_dacc <= '0;
                    r_hacc <= '0;
                    r_drem <= '0;
                    r_hrem <= '0;
                end
            end
            if (r_state == S_FIN) begin
                r_dacc <= r_dacc + w_dq[doa_pkg::ACC_W-1:0];
                r_hacc <= r_hacc + w_hq[doa_pkg::ACC_W-1:0];
                r_drem <= w_drem;
                r_hrem <= w_hrem;
            end
            if ((r_state == S_OUT) && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // multiply chain, one product level per cycle
    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_sum  <= i_cmd.sum;
            r_diff <= i_cmd.diff;
        end
        if (r_state == S_MUL1) begin
            r_kd   <= doa_pkg::KD_W'(i_cfg.wheel_diameter) * doa_pkg::KD_W'(doa_pkg::DIST_K);
            r_kh   <= doa_pkg::KH_W'(i_cfg.wheel_diameter) * doa_pkg::KH_W'(doa_pkg::MDEG_K);
            r_dden <= doa_pkg::DDEN_W'(i_cfg.counts_per_rev) *
                      doa_pkg::DDEN_W'(doa_pkg::DEN_K);
            r_hden <= doa_pkg::HDEN_W'(i_cfg.counts_per_rev) *
                      doa_pkg::HDEN_W'(i_cfg.track_width);
        end
        if (r_state == S_MUL2) begin
            r_pdl <= doa_pkg::NUM_W'(r_sum) *
                     doa_pkg::NUM_W'(r_kd[doa_pkg::ACC_W-1:0]);
            r_pdh <= doa_pkg::ACC_W'(r_sum) *
                     doa_pkg::ACC_W'(r_kd[doa_pkg::KD_W-1:doa_pkg::ACC_W]);
            r_hn  <= doa_pkg::NUM_W'(r_diff) * doa_pkg::NUM_W'(r_kh);
        end
        if (r_state == S_MUL3) begin
            r_dnum <= r_pdl + {r_pdh, {doa_pkg::ACC_W{1'b0}}} + doa_pkg::NUM_W'(r_drem);
            r_hnum <= r_hn + doa_pkg::NUM_W'(r_hrem);
        end
        if ((r_state == S_OUT) && w_slot_free) begin
            r_out.distance_total <= r_dacc;
            r_out.heading_total  <= r_hacc;
            r_out.valid_res      <= r_ok;
        end
    end

    `DOA_ASSERT_NOW(a_div_sync, i_clk, i_rst_n, 1'b1, w_ddone == w_hdone,
        "dividers finished apart")
    `DOA_ASSERT_NOW(a_div_state, i_clk, i_rst_n, w_ddone, r_state == S_DIV,
        "divider finished outside the divide phase")
    `DOA_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, (r_state == S_OUT) && w_slot_free,
        r_out_valid && (r_state == S_IDLE), "result not loaded")
    `DOA_ASSERT_NOW(a_take_idle, i_clk, i_rst_n, r_state != S_IDLE, !o_cmd_take,
        "command taken while busy")

endmodule

`default_nettype wire

FILE: rtl/differential_odometry_accumulator_core.sv
// Differential-drive odometry accumulator. Each transfer on the input side carries
// signed left and right encoder count changes (or a clear request) and yields exactly
// one result: wrapping 32-bit distance (um) and heading (mdeg) totals plus a flag that
// tells whether all three settings were nonzero. Division truncates toward zero and
// the remainders carry into the next item. An update item runs in order through
// the back end: command take, three multiply stages, divider start, divide phase (the
// two parallel restoring dividers step through all 64 numerator bits, then are seen
// done), finish and result register load, which waits while an unread result blocks
// it; a clear or skipped item goes from the take to the load. A two-deep command
// queue lets the input side keep accepting while the back end works or a result waits.
// Settings must be written only while the block is idle; it does not enforce this.
// top level: configuration registers, front end and back end
// depends on doa_pkg, doa_front, doa_back
`default_nettype none

module differential_odometry_accumulator_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             push,
    input  wire doa_pkg::t_in                     i_item,
    output logic                                  full,
    output logic                                  empty,
    input  wire logic                             pop,
    output doa_pkg::t_out                         o_result,
    input  wire logic                             i_cfg_we,
    input  wire logic [doa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [doa_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    doa_pkg::t_cfg r_cfg;
    doa_pkg::t_cmd w_cmd;
    logic          w_cmd_valid;
    logic          w_cmd_take;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wheel_diameter <= doa_pkg::WD_RESET;
            r_cfg.track_width    <= doa_pkg::TW_RESET;
            r_cfg.counts_per_rev <= doa_pkg::CPR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                doa_pkg::REG_WHEEL_DIAMETER: begin
                    r_cfg.wheel_diameter <= i_cfg_wdata[doa_pkg::WD_W-1:0];
                end
                doa_pkg::REG_TRACK_WIDTH: begin
                    r_cfg.track_width <= i_cfg_wdata[doa_pkg::TW_W-1:0];
                end
                doa_pkg::REG_COUNTS_PER_REV: begin
                    r_cfg.counts_per_rev <= i_cfg_wdata[doa_pkg::CPR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    doa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    doa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

FILE: sim/differential_odometry_accumulator_core_test.sv
// self-checking testbench for the differential odometry accumulator core
// depends on doa_pkg and differential_odometry_accumulator_core
`timescale 1ns / 100ps

module differential_odometry_accumulator_core_test;
    import doa_pkg::*;

    typedef enum logic {ROW_SETTINGS, ROW_ITEM} t_row_kind;

    // one line of the directed table: a settings change or an item
    typedef struct packed {
        t_row_kind kind;
        t_cfg      cfg;
        t_in       item;
        logic      has_want;
        t_out      want;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  push        = 1'b0;
    t_in                   odo_in      = '0;
    logic                  full;
    logic                  empty;
    logic                  pop         = 1'b0;
    t_out                  odo_out;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // predictor copy of settings and odometry state
    t_cfg        settings;
    bit   [31:0] dist_total;
    bit   [31:0] head_total;
    longint      dist_rem;
    longint      head_rem;

    t_out        pending_totals[$];
    t_out        oldest;
    t_stim_row   directed_rows[$];
    int          mismatches    = 0;
    int          src_idle_pct  = 19;
    int          sink_stall_pct = 19;

    differential_odometry_accumulator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_item      (odo_in),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .o_result    (odo_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // advance the predicted totals by one item and return the expected result
    function automatic t_out advance_odometry(t_in x);
        longint l, r, wd, tw, cpr;
        longint dist_num, dist_den, head_num, head_den, dist_q, head_q;
        bit     ok;
        t_out   res;
        wd  = longint'(settings.wheel_diameter);
        tw  = longint'(settings.track_width);
        cpr = longint'(settings.counts_per_rev);
        ok  = (wd != 0) && (tw != 0) && (cpr != 0);
        if (x.clear_totals) begin
            dist_total = '0;
            head_total = '0;
            dist_rem   = 0;
            head_rem   = 0;
        end else if (ok) begin
            l = longint'(x.left_delta);
            r = longint'(x.right_delta);
            // truncating divisions, remainders carried into the next item
            dist_num = (l + r) * 64'sd3141593 * wd * 64'sd1000 + dist_rem;
            dist_den = 64'sd2 * cpr * 64'sd1000000;
            head_num = (r - l) * wd * 64'sd180000 + head_rem;
            head_den = cpr * tw;
            dist_q   = dist_num / dist_den;
            dist_rem = dist_num % dist_den;
            head_q   = head_num / head_den;
            head_rem = head_num % head_den;
            dist_total += dist_q[31:0];
            head_total += head_q[31:0];
        end
        res.distance_total = dist_total;
        res.heading_total  = head_total;
        res.valid_res      = ok;
        return res;
    endfunction

    function automatic t_cfg make_cfg(int wd, int tw, int cpr);
        t_cfg c;
        c.wheel_diameter = WD_W'(wd);
        c.track_width    = TW_W'(tw);
        c.counts_per_rev = CPR_W'(cpr);
        return c;
    endfunction

    function automatic t_in make_item(int left, int right, bit clr);
        t_in x;
        x.left_delta   = DELTA_WIDTH'(left);
        x.right_delta  = DELTA_WIDTH'(right);
        x.clear_totals = clr;
        return x;
    endfunction

    function automatic void add_settings(int wd, int tw, int cpr);
        t_stim_row row;
        row      = '0;
        row.kind = ROW_SETTINGS;
        row.cfg  = make_cfg(wd, tw, cpr);
        directed_rows.push_back(row);
    endfunction

    function automatic void add_item(int left, int right, bit clr);
        t_stim_row row;
        row      = '0;
        row.kind = ROW_ITEM;
        row.item = make_item(left, right, clr);
        directed_rows.push_back(row);
    endfunction

    // item whose result is plain to see, such as zero totals or a skipped update
    function automatic void add_item_want(int left, int right, bit clr, int want_dist,
                                          int want_head, bit valid);
        t_stim_row row;
        row                     = '0;
        row.kind                = ROW_ITEM;
        row.item                = make_item(left, right, clr);
        row.has_want            = 1'b1;
        row.want.distance_total = want_dist;
        row.want.heading_total  = want_head;
        row.want.valid_res      = valid;
        directed_rows.push_back(row);
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(4))
            0: return 32767;
            1: return -32768;
            2: return 0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    // mostly plausible wheel motion, some full-range noise and extremes
    function automatic t_in random_motion();
        int kind, base;
        t_in x;
        kind = $urandom_range(99);
        if (kind < 40) begin
            base = $urandom_range(4000) - 2000;
            x = make_item(base, base + $urandom_range(64) - 32, 1'b0);
        end else if (kind < 70) begin
            x = make_item($urandom, $urandom, 1'b0);
        end else if (kind < 85) begin
            x = make_item(pick_extreme(), pick_extreme(), 1'b0);
        end else begin
            x = make_item($urandom_range(16) - 8, $urandom_range(16) - 8, 1'b0);
        end
        x.clear_totals = ($urandom_range(99) < 4);
        return x;
    endfunction

    // input transfer, with random idle cycles ahead of it
    task automatic send_item(t_in x, bit has_want, t_out want);
        t_out predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        odo_in <= x;
        do @(posedge i_clk); while (full);
        predicted = advance_odometry(x);
        pending_totals.push_back(has_want ? want : predicted);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending_totals.size() != 0) @(posedge i_clk);
    endtask

    // write all three registers, optionally with junk above the diameter and track fields
    task automatic apply_settings(t_cfg c, bit noisy);
        logic [CFG_DATA_W-1:0] noise;
        noise       = noisy ? CFG_DATA_W'($urandom) : '0;
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_WHEEL_DIAMETER;
        i_cfg_wdata <= {noise[CFG_DATA_W-1:WD_W], c.wheel_diameter};
        @(posedge i_clk);
        i_cfg_idx   <= REG_TRACK_WIDTH;
        i_cfg_wdata <= {noise[CFG_DATA_W-1:TW_W], c.track_width};
        @(posedge i_clk);
        i_cfg_idx   <= REG_COUNTS_PER_REV;
        i_cfg_wdata <= c.counts_per_rev;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        settings = c;
    endtask

    // result transfers checked against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_totals.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %p", $time, odo_out);
            end else begin
                oldest = pending_totals.pop_front();
                if (odo_out.distance_total !== oldest.distance_total) begin
                    mismatches++;
                    $display("%0t: distance_total expected %0d actual %0d", $time,
                             oldest.distance_total, odo_out.distance_total);
                end
                if (odo_out.heading_total !== oldest.heading_total) begin
                    mismatches++;
                    $display("%0t: heading_total expected %0d actual %0d", $time,
                             oldest.heading_total, odo_out.heading_total);
                end
                if (odo_out.valid_res !== oldest.valid_res) begin
                    mismatches++;
                    $display("%0t: valid_res expected %0b actual %0b", $time,
                             oldest.valid_res, odo_out.valid_res);
                end
            end
        end
        pop <= ($urandom_range(99) >= sink_stall_pct);
    end

    initial begin
        int   n_items;
        t_cfg c;

        settings   = make_cfg(int'(WD_RESET), int'(TW_RESET), int'(CPR_RESET));
        dist_total = '0;
        head_total = '0;
        dist_rem   = 0;
        head_rem   = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: zero motion, full revolution, extremes, then clear
        add_item_want(0, 0, 1'b0, 0, 0, 1'b1);
        add_item(1560, 1560, 1'b0);
        add_item(32767, 32767, 1'b0);
        add_item(-32768, -32768, 1'b0);
        add_item(32767, -32768, 1'b0);
        add_item(-32768, 32767, 1'b0);
        add_item(-1, 1, 1'b0);
        add_item_want(1234, -4321, 1'b1, 0, 0, 1'b1);
        // each register zero in turn: totals hold, update flagged as skipped
        add_settings(0, 160, 1560);
        add_item_want(100, 200, 1'b0, 0, 0, 1'b0);
        add_item_want(7, 9, 1'b1, 0, 0, 1'b0);
        add_settings(1023, 0, 1560);
        add_item_want(5, -7, 1'b0, 0, 0, 1'b0);
        add_settings(65, 160, 0);
        add_item_want(-3, 3, 1'b0, 0, 0, 1'b0);
        // largest settings
        add_settings(1023, 2047, 65535);
        add_item(32767, 32767, 1'b0);
        add_item(-32768, 32767, 1'b0);
        add_item(1, 1, 1'b0);
        add_item(-1, -1, 1'b0);
        // smallest settings, heading wraps past 32 bits
        add_settings(1, 1, 1);
        add_item(32767, 32767, 1'b0);
        add_item(32767, -32768, 1'b0);
        add_item(-32768, 32767, 1'b0);
        add_item(0, 0, 1'b0);
        // remainders from the old settings carry into the new ones
        add_settings(65, 160, 1560);
        add_item(3, 8, 1'b0);
        add_item_want(0, 0, 1'b1, 0, 0, 1'b1);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_SETTINGS) begin
                wait_drained();
                apply_settings(directed_rows[i].cfg, 1'b0);
            end else begin
                send_item(directed_rows[i].item, directed_rows[i].has_want,
                          directed_rows[i].want);
            end
        end

        // random phases, each under its own settings
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0: c = make_cfg(int'(WD_RESET), int'(TW_RESET), int'(CPR_RESET));
                1: c = make_cfg(1023, 2047, 65535);
                2: c = make_cfg(1, 1, 1);
                3: begin
                    c = make_cfg($urandom_range(1, 1023), $urandom_range(1, 2047),
                                 $urandom_range(1, 65535));
                    case ($urandom_range(2))
                        0: c.wheel_diameter = '0;
                        1: c.track_width    = '0;
                        default: c.counts_per_rev = '0;
                    endcase
                end
                default: c = make_cfg($urandom_range(1, 1023), $urandom_range(1, 2047),
                                      $urandom_range(1, 65535));
            endcase
            n_items = (phase == 3) ? 30 : 85;
            // one phase runs both sides flat out
            src_idle_pct   = (phase == 5) ? 0 : 19;
            sink_stall_pct = (phase == 5) ? 0 : 19;
            wait_drained();
            apply_settings(c, phase > 3);
            repeat (n_items) send_item(random_motion(), 1'b0, '0);
        end

        wait_drained();
        repeat (150) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/doa_pkg.sv
rtl/doa_div.sv
rtl/doa_front.sv
rtl/doa_back.sv
rtl/differential_odometry_accumulator_core.sv
sim/differential_odometry_accumulator_core_test.sv
